// ===== rtl/wtl_pkg.sv =====
// Shared types and constants of the whitespace token lexer.
package wtl_pkg;

    typedef enum logic [2:0] {
        KIND_NUMBER   = 3'd0,
        KIND_INSTR    = 3'd1,
        KIND_OPERATOR = 3'd2,
        KIND_END      = 3'd3,
        KIND_ERROR    = 3'd4
    } t_kind;

    localparam logic [2:0] INSTR_PUSH = 3'd0;
    localparam logic [2:0] INSTR_ADD  = 3'd1;
    localparam logic [2:0] INSTR_EXT  = 3'd2;

    localparam logic [2:0] OP_PLUS    = 3'd0;
    localparam logic [2:0] OP_MINUS   = 3'd1;
    localparam logic [2:0] OP_TIMES   = 3'd2;
    localparam logic [2:0] OP_DIVIDE  = 3'd3;
    localparam logic [2:0] OP_MODULUS = 3'd4;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_AT      = 8'h40;

    localparam logic [15:0] LINE_FIRST = 16'd1;
    localparam logic [15:0] LINE_MAX   = 16'hFFFF;

    localparam int KW_COUNT = 3;
    // push, add, ext; unused tail bytes never match because of the length check
    localparam logic [7:0] KW_TEXT [KW_COUNT][4] = '{
        '{8'h70, 8'h75, 8'h73, 8'h68},
        '{8'h61, 8'h64, 8'h64, 8'h00},
        '{8'h65, 8'h78, 8'h74, 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd3, 3'd3};

    localparam int Q_DEPTH = 4;
    localparam int Q_PW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        t_kind              kind;
        logic [2:0]         code;
        logic signed [31:0] value;
        logic [15:0]        line;
        logic               last;
    } t_result;

    // up to two results per accepted beat
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// ===== rtl/wtl_in_if.sv =====
// Input channel: one source byte per beat.
interface wtl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

// ===== rtl/wtl_out_if.sv =====
// Output channel: one token or end result per beat.
interface wtl_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         token_kind;
    logic [2:0]         token_code;
    logic signed [31:0] number_value;
    logic [15:0]        line_number;
    logic               last_of_source;

    modport source (output valid, output token_kind, output token_code,
                    output number_value, output line_number, output last_of_source,
                    input ready);
    modport sink   (input valid, input token_kind, input token_code,
                    input number_value, input line_number, input last_of_source,
                    output ready);
endinterface

// ===== rtl/whitespace_token_lexer.sv =====
// Top level of the whitespace token lexer.
// Takes one source byte every cycle and turns it into number, instruction
// and operator tokens, ending each source at byte 0 with a success or
// syntax-error beat marked last. A byte's results are written into the
// result queue and are then registered in the output register before they
// can leave the lexer. The classifier feeds a four-entry result
// queue ahead of the output register; input is held off while fewer than
// two queue entries are free, so input runs at one byte per cycle as long
// as the output drains one beat per cycle and stalls only behind a
// blocked output.
module whitespace_token_lexer #(
    parameter int MAX_LEXEME = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wtl_in_if.sink     i_in,
    wtl_out_if.source  o_out
);
    import wtl_pkg::*;

    t_push push;
    logic  room;

    wtl_front #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_char_byte (i_in.char_byte),
        .i_room      (room),
        .o_ready     (i_in.ready),
        .o_push      (push)
    );

    wtl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/wtl_front.sv =====
// Lexer front end: gathers bytes into lexemes and classifies them into results.
module wtl_front #(
    parameter int MAX_LEXEME = 255
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_char_byte,
    input  logic           i_room,
    output logic           o_ready,
    output wtl_pkg::t_push o_push
);
    import wtl_pkg::*;

    localparam int LW = $clog2(MAX_LEXEME + 1);

    typedef enum logic [2:0] {
        CLS_NONE, CLS_NUMBER, CLS_OPERATOR, CLS_COMMENT, CLS_WORD
    } t_cls;

    typedef enum logic [1:0] {PH_SIGN, PH_DIGIT, PH_STOP} t_phase;

    typedef enum logic [1:0] {FIN_NONE, FIN_TOKEN, FIN_ERROR} t_fin;

    function automatic logic [3:0] op_lookup(logic [7:0] ch);
        logic [3:0] res;
        case (ch)
            CH_PLUS:    res = {1'b1, OP_PLUS};
            CH_MINUS:   res = {1'b1, OP_MINUS};
            CH_STAR:    res = {1'b1, OP_TIMES};
            CH_SLASH:   res = {1'b1, OP_DIVIDE};
            CH_PERCENT: res = {1'b1, OP_MODULUS};
            default:    res = '0;
        endcase
        return res;
    endfunction

    logic [LW-1:0] r_len,    n_len;
    t_cls          r_cls,    n_cls;
    logic [2:0]    r_kw,     n_kw;
    logic [2:0]    r_op,     n_op;
    logic [31:0]   r_acc,    n_acc;
    t_phase        r_phase,  n_phase;
    logic          r_neg,    n_neg;
    logic [15:0]   r_line,   n_line;
    logic          r_halted, n_halted;

    logic       accept;
    logic       is_delim;
    logic       is_digit;
    logic [3:0] op_hit;
    logic       clr;
    t_fin       fin;
    t_result    fin_tok;
    t_result    err_res;
    t_result    end_res;
    t_push      push;

    assign o_ready  = i_room;
    assign accept   = i_valid && i_room;
    assign is_delim = (i_char_byte == CH_SPACE) || (i_char_byte inside {[CH_TAB:CH_CR]});
    assign is_digit = i_char_byte inside {[CH_ZERO:CH_NINE]};
    assign op_hit   = op_lookup(i_char_byte);
    assign err_res  = '{kind: KIND_ERROR, code: '0, value: '0, line: r_line, last: 1'b1};
    assign end_res  = '{kind: KIND_END, code: '0, value: '0, line: r_line, last: 1'b1};
    assign o_push   = push;

    // classification of the pending lexeme
    always_comb begin
        fin     = FIN_NONE;
        fin_tok = '{kind: KIND_NUMBER, code: '0, value: '0, line: r_line, last: 1'b0};
        if (r_len != '0 && r_cls != CLS_COMMENT) begin
            case (r_cls)
                CLS_NUMBER: begin
                    fin           = FIN_TOKEN;
                    fin_tok.value = r_neg ? -r_acc : r_acc;
                end
                CLS_OPERATOR: begin
                    if (r_len == LW'(1)) begin
                        fin          = FIN_TOKEN;
                        fin_tok.kind = KIND_OPERATOR;
                        fin_tok.code = r_op;
                    end else begin
                        fin = FIN_ERROR;
                    end
                end
                default: begin
                    fin          = FIN_TOKEN;
                    fin_tok.kind = KIND_INSTR;
                    if (r_kw[0] && r_len == LW'(KW_LEN[0])) begin
                        fin_tok.code = INSTR_PUSH;
                    end else if (r_kw[1] && r_len == LW'(KW_LEN[1])) begin
                        fin_tok.code = INSTR_ADD;
                    end else if (r_kw[2] && r_len == LW'(KW_LEN[2])) begin
                        fin_tok.code = INSTR_EXT;
                    end else begin
                        fin = FIN_ERROR;
                    end
                end
            endcase
        end
    end

    // per-beat update
    always_comb begin
        n_len    = r_len;
        n_cls    = r_cls;
        n_kw     = r_kw;
        n_op     = r_op;
        n_acc    = r_acc;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_line   = r_line;
        n_halted = r_halted;
        clr      = 1'b0;
        push     = '{n: 2'd0, r0: fin_tok, r1: end_res};
        if (accept) begin
            if (i_char_byte == CH_NUL) begin
                if (!r_halted) begin
                    if (fin == FIN_ERROR) begin
                        push.n  = 2'd1;
                        push.r0 = err_res;
                    end else if (fin == FIN_TOKEN) begin
                        push.n  = 2'd2;
                    end else begin
                        push.n  = 2'd1;
                        push.r0 = end_res;
                    end
                end
                clr      = 1'b1;
                n_line   = LINE_FIRST;
                n_halted = 1'b0;
            end else if (!r_halted) begin
                if (is_delim) begin
                    clr = 1'b1;
                    if (fin == FIN_ERROR) begin
                        push.n   = 2'd1;
                        push.r0  = err_res;
                        n_halted = 1'b1;
                    end else begin
                        push.n = (fin == FIN_TOKEN) ? 2'd1 : 2'd0;
                        if (i_char_byte == CH_LF && r_line != LINE_MAX) begin
                            n_line = r_line + 16'd1;
                        end
                    end
                end else if (r_len >= LW'(MAX_LEXEME)) begin
                    clr      = 1'b1;
                    push.n   = 2'd1;
                    push.r0  = err_res;
                    n_halted = 1'b1;
                end else begin
                    if (r_len == '0) begin
                        if (i_char_byte == CH_HASH) begin
                            n_cls = CLS_NUMBER;
                        end else if (op_hit[3]) begin
                            n_cls = CLS_OPERATOR;
                            n_op  = op_hit[2:0];
                        end else if (i_char_byte == CH_AT) begin
                            n_cls = CLS_COMMENT;
                        end else begin
                            n_cls = CLS_WORD;
                        end
                    end else if (r_cls == CLS_NUMBER && r_phase != PH_STOP) begin
                        if (is_digit) begin
                            n_acc   = (r_acc << 3) + (r_acc << 1) + {28'd0, i_char_byte[3:0]};
                            n_phase = PH_DIGIT;
                        end else if (r_phase == PH_SIGN
                                     && (i_char_byte == CH_PLUS || i_char_byte == CH_MINUS)) begin
                            n_neg   = (i_char_byte == CH_MINUS);
                            n_phase = PH_DIGIT;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end
                    for (int i = 0; i < KW_COUNT; i++) begin
                        if (!(r_len < LW'(KW_LEN[i]) && KW_TEXT[i][r_len[1:0]] == i_char_byte)) begin
                            n_kw[i] = 1'b0;
                        end
                    end
                    n_len = r_len + LW'(1);
                end
            end
        end
        if (clr) begin
            n_len   = '0;
            n_cls   = CLS_NONE;
            n_kw    = '1;
            n_op    = '0;
            n_acc   = '0;
            n_phase = PH_SIGN;
            n_neg   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_cls    <= CLS_NONE;
            r_kw     <= '1;
            r_op     <= '0;
            r_acc    <= '0;
            r_phase  <= PH_SIGN;
            r_neg    <= 1'b0;
            r_line   <= LINE_FIRST;
            r_halted <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_cls    <= n_cls;
            r_kw     <= n_kw;
            r_op     <= n_op;
            r_acc    <= n_acc;
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_line   <= n_line;
            r_halted <= n_halted;
        end
    end

    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_char_byte == CH_NUL)
        |=> (r_len == '0 && !r_halted && r_line == LINE_FIRST))
        else $error("end of source did not restart the lexer");

    a_pair_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.n == 2'd2) |-> (push.r1.kind == KIND_END && push.r1.last && !push.r0.last))
        else $error("second result of a beat is not the end result");

    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_char_byte != CH_NUL && push.n != 2'd0 && push.r0.kind == KIND_ERROR)
        |=> r_halted)
        else $error("syntax error did not halt the lexer");

endmodule

// ===== rtl/wtl_queue.sv =====
// Result queue and output register: takes up to two results a beat, hands out one.
module wtl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wtl_pkg::t_push i_push,
    output logic           o_room,
    wtl_out_if.source      o_out
);
    import wtl_pkg::*;

    t_result          r_mem [Q_DEPTH];
    logic [Q_PW-1:0]  r_wp, n_wp;
    logic [Q_PW-1:0]  r_rp, n_rp;
    logic [Q_CW-1:0]  r_count, n_count;
    logic             r_out_valid, n_out_valid;
    t_result          r_out;
    logic             pop;

    assign o_room  = r_count <= Q_CW'(Q_DEPTH - 2);
    assign pop     = (r_count != '0) && (!r_out_valid || o_out.ready);
    assign n_wp    = r_wp + Q_PW'(i_push.n);
    assign n_rp    = r_rp + Q_PW'(pop);
    assign n_count = r_count + Q_CW'(i_push.n) - Q_CW'(pop);
    assign n_out_valid = pop || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wp + Q_PW'(1)] <= i_push.r1;
        end
        if (pop) begin
            r_out <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.token_kind     = r_out.kind;
    assign o_out.token_code     = r_out.code;
    assign o_out.number_value   = r_out.value;
    assign o_out.line_number    = r_out.line;
    assign o_out.last_of_source = r_out.last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |-> (r_count <= Q_CW'(Q_DEPTH - 2)))
        else $error("results pushed into a full queue");

endmodule
